// ----- rtl/dad_pkg.sv -----
// Package for the Gregorian date adder: field widths, calendar constants,
// the sequencer's control word format and its program, and the month length table.
// No dependencies.
`default_nettype none

package dad_pkg;

  // Field widths of the item payloads.
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned AddW   = 15;

  // Internal widths: the running count covers a year plus the day and the
  // added days; the year counter holds the start year plus the years walked.
  localparam int unsigned RemW   = 16;
  localparam int unsigned YearIW = YearW + 1;
  localparam int unsigned PcW    = 3;

  // Calendar constants.
  localparam int unsigned LeapCycle  = 400;
  localparam int unsigned Century    = 100;
  localparam int unsigned MonthsYear = 12;
  localparam int unsigned FebLeap    = 29;

  // Datapath operations selected by a control word.
  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_LOAD   = 3'd1,
    OP_MOD    = 3'd2,
    OP_SUM    = 3'd3,
    OP_REWIND = 3'd4,
    OP_WALK   = 3'd5,
    OP_EMIT   = 3'd6
  } op_e;

  // Jump conditions; when the condition holds the sequencer goes to the
  // target, otherwise to the next step.
  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_IN    = 3'd2,
    COND_GE_CYCLE = 3'd3,
    COND_M_LT_MON = 3'd4,
    COND_REM_GT   = 3'd5,
    COND_OUT_BUSY = 3'd6
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ucode_t;

  // Step addresses of the program.
  localparam logic [PcW-1:0] StepIdle   = 3'd0;
  localparam logic [PcW-1:0] StepMod    = 3'd1;
  localparam logic [PcW-1:0] StepSum    = 3'd2;
  localparam logic [PcW-1:0] StepRewind = 3'd3;
  localparam logic [PcW-1:0] StepWalk   = 3'd4;
  localparam logic [PcW-1:0] StepEmit   = 3'd5;
  localparam logic [PcW-1:0] StepRet    = 3'd6;

  // The program: wait for an item, reduce the year modulo the leap cycle, sum
  // the months before the start month, rewind, walk forward and emit the result.
  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    unique case (pc)
      StepIdle:   w = '{op: OP_LOAD,   cond: COND_NO_IN,    target: StepIdle};
      StepMod:    w = '{op: OP_MOD,    cond: COND_GE_CYCLE, target: StepMod};
      StepSum:    w = '{op: OP_SUM,    cond: COND_M_LT_MON, target: StepSum};
      StepRewind: w = '{op: OP_REWIND, cond: COND_NEVER,    target: StepIdle};
      StepWalk:   w = '{op: OP_WALK,   cond: COND_REM_GT,   target: StepWalk};
      StepEmit:   w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, target: StepEmit};
      StepRet:    w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: StepIdle};
      default:    w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: StepIdle};
    endcase
    return w;
  endfunction

  // Length of a month; months outside January to December have no days.
  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] m,
                                              input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? DayW'(FebLeap) : 5'd28;
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dad_in_if.sv -----
// Input channel of the date adder: valid/ready handshake and the start date item.
// Depends on dad_pkg for the field widths.
`default_nettype none

interface dad_in_if;
  import dad_pkg::*;

  logic              valid;
  logic              ready;
  logic [DayW-1:0]   start_day;
  logic [MonthW-1:0] start_month;
  logic [YearW-1:0]  start_year;
  logic [AddW-1:0]   days_to_add;

  modport source (output valid, start_day, start_month, start_year, days_to_add,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/dad_out_if.sv -----
// Output channel of the date adder: valid/ready handshake and the result date item.
// Depends on dad_pkg for the field widths.
`default_nettype none

interface dad_out_if;
  import dad_pkg::*;

  logic              valid;
  logic              ready;
  logic [DayW-1:0]   result_day;
  logic [MonthW-1:0] result_month;
  logic [YearW-1:0]  result_year;

  modport source (output valid, result_day, result_month, result_year,
                  input ready);
  modport sink   (input valid, result_day, result_month, result_year,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/date_add_days.sv -----
// Top level of the Gregorian date adder: microcoded sequencer and its datapath.
// Depends on dad_pkg, dad_in_if and dad_out_if.
//
//   channel  direction  carries
//   in_i     sink       start_day, start_month, start_year, days_to_add
//   out_o    source     result_day, result_month, result_year
//
// One item is in work at a time. An item is accepted, its year is reduced modulo
// 400, the months before its start month are summed, the month counter is rewound
// to January and the months are walked forward one by one (up to about 1090 months
// for a full year of month sums, a start day of 31 and 32767 days); the result is
// then handed to the output register once that register can take it.
// A finished result waits in the output register while the next item is taken.
// Reset is asynchronous, active low, and returns the sequencer to its idle step.
`default_nettype none

module date_add_days
  import dad_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  dad_in_if.sink    in_i,
  dad_out_if.source out_o
);

  // Sequencer state.
  logic [PcW-1:0] pc_q, pc_d;
  logic           out_valid_q, out_valid_d;

  // Datapath registers.
  logic [RemW-1:0]   rem_q, rem_d;
  logic [MonthW-1:0] mon_q, mon_d;
  logic [MonthW-1:0] m_q, m_d;
  logic [YearIW-1:0] year_q, year_d;
  logic [YearW-1:0]  ymod_q, ymod_d;
  logic [DayW-1:0]   res_day_q, res_day_d;
  logic [MonthW-1:0] res_month_q, res_month_d;
  logic [YearW-1:0]  res_year_q, res_year_d;

  ucode_t          word;
  logic            in_fire;
  logic            out_busy;
  logic            leap;
  logic [DayW-1:0] len;
  logic            ge_cycle;
  logic            m_lt_mon;
  logic            rem_gt;
  logic            jump;

  // Handshake signals.
  assign word     = ucode_rom(pc_q);
  assign in_i.ready = (word.op == OP_LOAD);
  assign in_fire  = in_i.valid & in_i.ready;
  assign out_busy = out_valid_q & ~out_o.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.result_day   = res_day_q;
  assign out_o.result_month = res_month_q;
  assign out_o.result_year  = res_year_q;

  // Leap test from the year modulo 400 and the low bits of the year.
  assign leap = (ymod_q == '0) ||
                ((year_q[1:0] == 2'b00) &&
                 (ymod_q != YearW'(Century)) &&
                 (ymod_q != YearW'(2 * Century)) &&
                 (ymod_q != YearW'(3 * Century)));

  assign len      = days_in(m_q, leap);
  assign ge_cycle = (ymod_q >= YearW'(LeapCycle));
  assign m_lt_mon = (m_q < mon_q);
  assign rem_gt   = (rem_q > RemW'(len));

  // Jump condition select.
  always_comb begin
    unique case (word.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_IN:    jump = ~in_fire;
      COND_GE_CYCLE: jump = ge_cycle;
      COND_M_LT_MON: jump = m_lt_mon;
      COND_REM_GT:   jump = rem_gt;
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b1;
    endcase
  end

  assign pc_d = jump ? word.target : pc_q + 3'd1;

  // Datapath operations.
  always_comb begin
    rem_d       = rem_q;
    mon_d       = mon_q;
    m_d         = m_q;
    year_d      = year_q;
    ymod_d      = ymod_q;
    res_day_d   = res_day_q;
    res_month_d = res_month_q;
    res_year_d  = res_year_q;
    out_valid_d = out_valid_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (word.op)
      OP_LOAD: begin
        if (in_fire) begin
          rem_d  = RemW'(in_i.start_day) + RemW'(in_i.days_to_add);
          mon_d  = in_i.start_month;
          m_d    = 4'd1;
          year_d = YearIW'(in_i.start_year);
          ymod_d = in_i.start_year;
        end
      end
      OP_MOD: begin
        if (ge_cycle) begin
          ymod_d = ymod_q - YearW'(LeapCycle);
        end
      end
      OP_SUM: begin
        if (m_lt_mon) begin
          rem_d = rem_q + RemW'(len);
          m_d   = m_q + 4'd1;
        end
      end
      OP_REWIND: begin
        m_d = 4'd1;
      end
      OP_WALK: begin
        // Take away one whole month; December wraps into the next year.
        if (rem_gt) begin
          rem_d = rem_q - RemW'(len);
          if (m_q == MonthW'(MonthsYear)) begin
            m_d    = 4'd1;
            year_d = year_q + YearIW'(1);
            ymod_d = (ymod_q == YearW'(LeapCycle - 1)) ? '0 : ymod_q + YearW'(1);
          end else begin
            m_d = m_q + 4'd1;
          end
        end
      end
      OP_EMIT: begin
        if (!out_busy) begin
          res_day_d   = rem_q[DayW-1:0];
          res_month_d = m_q;
          res_year_d  = year_q[YearW-1:0];
          out_valid_d = 1'b1;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StepIdle;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    mon_q       <= mon_d;
    m_q         <= m_d;
    year_q      <= year_d;
    ymod_q      <= ymod_d;
    res_day_q   <= res_day_d;
    res_month_q <= res_month_d;
    res_year_q  <= res_year_d;
  end

endmodule

`default_nettype wire

// ----- tb/sv/date_add_days_checker.sv -----
// Checker for the Gregorian date adder: watches both channels, predicts each result
// date from the accepted start date and compares it field by field.
// Depends on dad_pkg, dad_in_if and dad_out_if.
`timescale 1ns / 1ps

module date_add_days_checker
  import dad_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  dad_in_if           mon_in_i,
  dad_out_if          mon_out_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_results_o
);

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  date_t       later_dates_q[$];
  int unsigned mismatches = 0;

  assign mismatch_count_o  = mismatches;
  assign pending_results_o = later_dates_q.size();

  // Gregorian leap rule on the full, unwrapped year count.
  function automatic bit is_leap_year(input int unsigned yr);
    return (yr % LeapCycle == 0) || ((yr % 4 == 0) && (yr % Century != 0));
  endfunction

  // Days in a month; anything outside January to December counts as empty.
  function automatic int unsigned month_days(input int unsigned mon, input int unsigned yr);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap_year(yr) ? FebLeap : 28;
      default:               return 0;
    endcase
  endfunction

  // Day of year from the start month, then a month-by-month walk from January.
  function automatic date_t later_date(input logic [DayW-1:0]   day,
                                       input logic [MonthW-1:0] month,
                                       input logic [YearW-1:0]  year,
                                       input logic [AddW-1:0]   add);
    int unsigned count;
    int unsigned yr;
    int unsigned mon;
    date_t       d;
    yr    = year;
    count = 0;
    for (mon = 1; mon < month; mon++) begin
      count += month_days(mon, yr);
    end
    count += day + add;
    mon = 1;
    while (count > month_days(mon, yr)) begin
      count -= month_days(mon, yr);
      mon++;
      if (mon > MonthsYear) begin
        mon = 1;
        yr++;
      end
    end
    d.day   = count[DayW-1:0];
    d.month = mon[MonthW-1:0];
    d.year  = yr[YearW-1:0];
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] date mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Results are compared before the item of the same edge is queued, since an
  // item can never produce its result in the cycle it is accepted.
  always @(posedge clk_i) begin
    date_t want;
    if (rst_ni) begin
      if (mon_out_i.valid && mon_out_i.ready) begin
        if (later_dates_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d/%0d arrived with none expected",
                                    mon_out_i.result_day, mon_out_i.result_month,
                                    mon_out_i.result_year));
        end else begin
          want = later_dates_q.pop_front();
          if (mon_out_i.result_day !== want.day)
            report_mismatch($sformatf("result_day got %0d, expected %0d",
                                      mon_out_i.result_day, want.day));
          if (mon_out_i.result_month !== want.month)
            report_mismatch($sformatf("result_month got %0d, expected %0d",
                                      mon_out_i.result_month, want.month));
          if (mon_out_i.result_year !== want.year)
            report_mismatch($sformatf("result_year got %0d, expected %0d",
                                      mon_out_i.result_year, want.year));
        end
      end
      if (mon_in_i.valid && mon_in_i.ready) begin
        later_dates_q.push_back(later_date(mon_in_i.start_day, mon_in_i.start_month,
                                           mon_in_i.start_year, mon_in_i.days_to_add));
      end
    end
  end

endmodule

// ----- tb/sv/date_add_days_tb.sv -----
// Testbench top for the Gregorian date adder: clock, reset, start date stimulus,
// result side flow control, watchdog and verdict.
// Depends on dad_pkg, dad_in_if, dad_out_if, date_add_days and date_add_days_checker.
`timescale 1ns / 1ps

module date_add_days_tb
  import dad_pkg::*;
();

  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned PhaseItems    = 180;
  localparam int unsigned BurstItems    = 10;
  localparam int unsigned LongHold      = 4000;
  localparam int unsigned TailCycles    = 1200;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  bit          long_hold_req  = 1'b0;
  logic        in_fire        = 1'b0;
  logic        out_fire       = 1'b0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatch_count;
  int unsigned pending_results;

  dad_in_if  in_ch ();
  dad_out_if out_ch ();

  date_add_days DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  date_add_days_checker checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mon_in_i          (in_ch),
    .mon_out_i         (out_ch),
    .mismatch_count_o  (mismatch_count),
    .pending_results_o (pending_results)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Handshakes are registered at the rising edge and looked at on the falling one.
  always @(posedge clk_i) begin
    in_fire  <= in_ch.valid && in_ch.ready;
    out_fire <= out_ch.valid && out_ch.ready;
  end

  // Watchdog: ends the run after too long without any item moving.
  always @(negedge clk_i) begin
    if (in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offers one start date after random gaps and returns once it is taken.
  task automatic send_date(input logic [DayW-1:0]   day,
                           input logic [MonthW-1:0] month,
                           input logic [YearW-1:0]  year,
                           input logic [AddW-1:0]   add);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid       <= 1'b0;
      in_ch.start_day   <= DayW'($urandom());
      in_ch.start_month <= MonthW'($urandom());
      in_ch.start_year  <= YearW'($urandom());
      in_ch.days_to_add <= AddW'($urandom());
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.start_day   <= day;
    in_ch.start_month <= month;
    in_ch.start_year  <= year;
    in_ch.days_to_add <= add;
    do @(negedge clk_i); while (!in_fire);
  endtask

  // Mostly plausible dates with short spans; some odd fields and long spans.
  task automatic send_random_date();
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [AddW-1:0]   add;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)      day = DayW'($urandom_range(1, 28));
    else if (pick < 95) day = DayW'($urandom_range(1, 31));
    else                day = DayW'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 90) month = MonthW'($urandom_range(1, 12));
    else           month = MonthW'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 75)      year = YearW'($urandom_range(0, 9999));
    else if (pick < 88) year = YearW'($urandom_range(1, 99) * 100 - 1 + $urandom_range(0, 2));
    else                year = YearW'($urandom_range(0, 16383));
    pick = $urandom_range(0, 99);
    if (pick < 60)      add = AddW'($urandom_range(0, 400));
    else if (pick < 75) add = AddW'($urandom_range(0, 3000));
    else if (pick < 95) add = AddW'($urandom_range(0, 32767));
    else                add = AddW'(32767 - $urandom_range(0, 31));
    send_date(day, month, year, add);
  endtask

  // Stops offering until every expected result has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_results != 0);
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.start_day   = '0;
    in_ch.start_month = '0;
    in_ch.start_year  = '0;
    in_ch.days_to_add = '0;
    out_ch.ready      = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed dates: leap rule corners, field extremes and malformed dates.
    send_idle_pct = 8;
    recv_idle_pct = 62;
    send_date(5'd1,  4'd1,  14'd2000,  15'd0);
    send_date(5'd28, 4'd2,  14'd2000,  15'd1);
    send_date(5'd28, 4'd2,  14'd1900,  15'd1);
    send_date(5'd28, 4'd2,  14'd2004,  15'd1);
    send_date(5'd28, 4'd2,  14'd2100,  15'd1);
    send_date(5'd31, 4'd1,  14'd2000,  15'd29);
    send_date(5'd1,  4'd3,  14'd2000,  15'd365);
    send_date(5'd29, 4'd2,  14'd1600,  15'd1461);
    send_date(5'd31, 4'd12, 14'd1999,  15'd0);
    send_date(5'd31, 4'd12, 14'd9999,  15'd1);
    send_date(5'd31, 4'd12, 14'd0,     15'd0);
    send_date(5'd1,  4'd1,  14'd0,     15'd32767);
    send_date(5'd16, 4'd8,  14'd2023,  15'd32767);
    // Start day zero with nothing added stays on day zero of January.
    send_date(5'd0,  4'd0,  14'd2023,  15'd0);
    send_date(5'd0,  4'd1,  14'd2023,  15'd0);
    send_date(5'd0,  4'd1,  14'd2023,  15'd1);
    // Months outside the calendar: zero adds nothing, high ones add a whole year.
    send_date(5'd15, 4'd0,  14'd2020,  15'd10);
    send_date(5'd1,  4'd13, 14'd2019,  15'd0);
    send_date(5'd31, 4'd15, 14'd2020,  15'd100);
    // Days past the end of their month roll forward.
    send_date(5'd31, 4'd2,  14'd2021,  15'd0);
    send_date(5'd31, 4'd4,  14'd2021,  15'd0);
    // Year counter wrapping past the field width.
    send_date(5'd1,  4'd1,  14'd16383, 15'd0);
    send_date(5'd31, 4'd14, 14'd16383, 15'd0);
    send_date(5'd31, 4'd12, 14'd16383, 15'd32767);
    wait_for_results();

    // Sender mostly busy, receiver often stalled.
    repeat (PhaseItems) send_random_date();
    wait_for_results();

    // Sender often idle, receiver mostly ready.
    send_idle_pct = 62;
    recv_idle_pct = 8;
    repeat (PhaseItems) send_random_date();
    wait_for_results();

    // No idling; first hold the result side off so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b1;
    repeat (BurstItems) begin
      send_date(DayW'($urandom_range(1, 28)), MonthW'($urandom_range(1, 12)),
                YearW'($urandom_range(0, 9999)), AddW'($urandom_range(0, 60)));
    end
    repeat (PhaseItems - BurstItems) send_random_date();
    wait_for_results();

    // Let the block run on for a while to catch any stray result.
    repeat (TailCycles) @(negedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dad_pkg.sv
rtl/dad_in_if.sv
rtl/dad_out_if.sv
rtl/date_add_days.sv
tb/sv/date_add_days_checker.sv
tb/sv/date_add_days_tb.sv
